// ===== sv/cpec_pkg.sv =====
`timescale 1ns / 1ps

package cpec_pkg;

  // Datapath widths shared by the CORDIC units and the top level.
  localparam int CW = 34;
  localparam int AW = 32;
  localparam int MAX_STEPS = 24;

  localparam logic [AW-1:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [AW-1:0] HALF_TURN = 32'h8000_0000;
  localparam logic signed [30:0] GAIN_Q30 = 31'sd652032874;

  // Divider geometry: quotients are known to stay below 2^QUO_W.
  localparam int DEN_W = 17;
  localparam int QUO_W = 21;
  localparam int NUM_W = DEN_W + QUO_W;
  localparam int DIV_LAT = QUO_W + 2;

  // Arctangent of 2^-i as a binary angle, 2^32 per turn.
  function automatic logic [AW-1:0] atan_of(input int i);
    logic [AW-1:0] r;
    unique case (i)
      0:  r = 32'h20000000;
      1:  r = 32'h12E4051E;
      2:  r = 32'h09FB385B;
      3:  r = 32'h051111D4;
      4:  r = 32'h028B0D43;
      5:  r = 32'h0145D7E1;
      6:  r = 32'h00A2F61E;
      7:  r = 32'h00517C55;
      8:  r = 32'h0028BE53;
      9:  r = 32'h00145F2F;
      10: r = 32'h000A2F98;
      11: r = 32'h000517CC;
      12: r = 32'h00028BE6;
      13: r = 32'h000145F3;
      14: r = 32'h0000A2FA;
      15: r = 32'h0000517D;
      16: r = 32'h000028BE;
      17: r = 32'h0000145F;
      18: r = 32'h00000A30;
      19: r = 32'h00000518;
      20: r = 32'h0000028C;
      21: r = 32'h00000146;
      22: r = 32'h000000A3;
      23: r = 32'h00000051;
      default: r = '0;
    endcase
    return r;
  endfunction

  // One request as it travels down the pipeline.
  typedef struct packed {
    logic signed [23:0] ax;
    logic signed [23:0] ay;
    logic [15:0] spa;
    logic [15:0] ha;
    logic [15:0] ma;
    logic signed [23:0] bx;
    logic signed [23:0] by;
    logic [15:0] spb;
    logic [15:0] hb;
    logic [15:0] mb;
    logic [23:0] cd;
    logic [16:0] rest;
  } item_t;

  typedef struct packed {
    logic signed [31:0] sa;
    logic signed [31:0] ca;
    logic signed [31:0] sb;
    logic signed [31:0] cb;
  } trig_t;

  typedef struct packed {
    logic signed [31:0] sn;
    logic signed [31:0] cn;
  } ntrig_t;

  typedef struct packed {
    logic signed [QUO_W:0] qa1;
    logic signed [QUO_W:0] qa2;
    logic signed [QUO_W:0] qb1;
    logic signed [QUO_W:0] qb2;
  } quo_t;

  typedef struct packed {
    logic signed [23:0] xa1;
    logic signed [23:0] xa2;
    logic signed [23:0] ya1;
    logic signed [23:0] ya2;
    logic signed [23:0] xb1;
    logic signed [23:0] xb2;
    logic signed [23:0] yb1;
    logic signed [23:0] yb2;
  } prod_t;

  typedef struct packed {
    logic signed [29:0] ox;
    logic signed [29:0] oy;
  } ofs_t;

endpackage

// ===== sv/circle_pair_elastic_collision.sv =====
`timescale 1ns / 1ps

// Resolves one pair of circular particles per request.
// Input: a request is taken at each rising edge where start is high and busy
// is low. busy is always low, so a new pair may enter every cycle.
// Output: each result appears for one cycle with done high and must be taken
// in that cycle. hit tells whether the pair overlapped and was resolved;
// otherwise the positions, speeds and headings echo the request.
// The result passes through three CORDIC passes in series (the distance and
// tangent, the tangent's sine and cosine, the two speed sums back to polar
// form) and through the 21-stage mass-ratio dividers, which run alongside the
// first two passes.
// Throughput: one request per cycle; nothing is shared between requests.
// Reset clears every valid bit in the pipeline, so no result follows reset
// until new requests arrive. The receiver cannot stall.
module circle_pair_elastic_collision #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic signed [23:0] pos_a_x,
  input  logic signed [23:0] pos_a_y,
  input  logic [15:0] speed_a,
  input  logic [15:0] heading_a,
  input  logic [15:0] mass_a,
  input  logic signed [23:0] pos_b_x,
  input  logic signed [23:0] pos_b_y,
  input  logic [15:0] speed_b,
  input  logic [15:0] heading_b,
  input  logic [15:0] mass_b,
  input  logic [23:0] contact_distance,
  input  logic [16:0] restitution,
  output logic done,
  output logic hit,
  output logic signed [23:0] new_a_x,
  output logic signed [23:0] new_a_y,
  output logic [15:0] new_speed_a,
  output logic [15:0] new_heading_a,
  output logic signed [23:0] new_b_x,
  output logic signed [23:0] new_b_y,
  output logic [15:0] new_speed_b,
  output logic [15:0] new_heading_b
);

  localparam int CW = cpec_pkg::CW;
  localparam int AW = cpec_pkg::AW;
  localparam int QW = cpec_pkg::QUO_W;
  localparam int L = CORDIC_STEPS + 2;
  localparam int QD = 1 + cpec_pkg::DIV_LAT;
  localparam int M = (2 * L > QD) ? 2 * L : QD;
  localparam int V = M + 2 + L;
  localparam int LAST = V + 1;
  localparam int LAT = LAST + 2;

  // Position plus rounded Q.12 offset, saturated to 24-bit signed.
  function automatic logic signed [23:0] pos_sat(input logic signed [23:0] p,
                                                 input logic signed [30:0] d);
    logic signed [30:0] t;
    logic signed [31:0] s;
    t = (d + 31'sd8) >>> 4;
    s = 32'(p) + 32'(t);
    if (s > 32'sd8388607) return 24'sh7FFFFF;
    if (s < -32'sd8388608) return 24'sh800000;
    return s[23:0];
  endfunction

  assign busy = 1'b0;

  // Request line: the request and its valid bit travel to the output.
  cpec_pkg::item_t itm [LAST+1];
  logic vld [LAST+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    itm[0] <= '{ax: pos_a_x, ay: pos_a_y, spa: speed_a, ha: heading_a, ma: mass_a,
                bx: pos_b_x, by: pos_b_y, spb: speed_b, hb: heading_b, mb: mass_b,
                cd: contact_distance, rest: restitution};
  end

  for (genvar k = 1; k <= LAST; k++) begin : g_line
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= vld[k-1];
      end
    end
    always_ff @(posedge clk) begin
      itm[k] <= itm[k-1];
    end
  end

  // First pass: center distance and tangent, and both input headings.
  logic signed [24:0] dx;
  logic signed [24:0] dy;
  logic signed [CW-1:0] sep;
  logic [AW-1:0] tang;
  logic signed [CW-1:0] ca_o;
  logic signed [CW-1:0] sa_o;
  logic signed [CW-1:0] cb_o;
  logic signed [CW-1:0] sb_o;

  assign dx = 25'(itm[0].ax) - 25'(itm[0].bx);
  assign dy = 25'(itm[0].ay) - 25'(itm[0].by);

  cpec_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b1)) u_vdist (
    .clk(clk), .x_in(CW'(dx) <<< 4), .y_in(CW'(dy) <<< 4), .z_in('0),
    .x_out(sep), .y_out(), .z_out(tang)
  );

  cpec_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b0)) u_rha (
    .clk(clk), .x_in(CW'(cpec_pkg::GAIN_Q30)), .y_in('0), .z_in({itm[0].ha, 16'h0000}),
    .x_out(ca_o), .y_out(sa_o), .z_out()
  );

  cpec_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b0)) u_rhb (
    .clk(clk), .x_in(CW'(cpec_pkg::GAIN_Q30)), .y_in('0), .z_in({itm[0].hb, 16'h0000}),
    .x_out(cb_o), .y_out(sb_o), .z_out()
  );

  // Mass-weighted speed numerators; a zero mass counts as one.
  logic [15:0] ma1;
  logic [15:0] mb1;
  logic signed [16:0] dab;
  logic signed [16:0] dba;
  logic signed [cpec_pkg::NUM_W-1:0] n_a1;
  logic signed [cpec_pkg::NUM_W-1:0] n_a2;
  logic signed [cpec_pkg::NUM_W-1:0] n_b1;
  logic signed [cpec_pkg::NUM_W-1:0] n_b2;
  logic [cpec_pkg::DEN_W-1:0] tot;

  assign ma1 = (itm[0].ma == '0) ? 16'd1 : itm[0].ma;
  assign mb1 = (itm[0].mb == '0) ? 16'd1 : itm[0].mb;
  assign dab = $signed({1'b0, ma1}) - $signed({1'b0, mb1});
  assign dba = $signed({1'b0, mb1}) - $signed({1'b0, ma1});

  always_ff @(posedge clk) begin
    n_a1 <= $signed({1'b0, itm[0].spa, 4'h0}) * dab;
    n_a2 <= $signed({1'b0, 37'({itm[0].spb, 5'h00}) * 37'(mb1)});
    n_b1 <= $signed({1'b0, itm[0].spb, 4'h0}) * dba;
    n_b2 <= $signed({1'b0, 37'({itm[0].spa, 5'h00}) * 37'(ma1)});
    tot <= 17'(ma1) + 17'(mb1);
  end

  cpec_pkg::quo_t qd [QD:M];

  cpec_div u_div_a1 (.clk(clk), .num(n_a1), .den(tot), .quo(qd[QD].qa1));
  cpec_div u_div_a2 (.clk(clk), .num(n_a2), .den(tot), .quo(qd[QD].qa2));
  cpec_div u_div_b1 (.clk(clk), .num(n_b1), .den(tot), .quo(qd[QD].qb1));
  cpec_div u_div_b2 (.clk(clk), .num(n_b2), .den(tot), .quo(qd[QD].qb2));

  for (genvar k = QD + 1; k <= M; k++) begin : g_qd
    always_ff @(posedge clk) begin
      qd[k] <= qd[k-1];
    end
  end

  // Overlap test and push-apart distance.
  logic hitl [L+1:LAST];
  logic signed [29:0] ovl [L+1:M];
  logic signed [CW-1:0] cd12;
  logic signed [CW:0] ovw;

  assign cd12 = $signed({6'd0, itm[L].cd, 4'h0});
  assign ovw = (CW+1)'(cd12) - (CW+1)'(sep) + (CW+1)'(4096);

  always_ff @(posedge clk) begin
    hitl[L+1] <= sep < cd12;
    ovl[L+1] <= 30'(ovw >>> 1);
  end

  for (genvar k = L + 2; k <= LAST; k++) begin : g_hit
    always_ff @(posedge clk) begin
      hitl[k] <= hitl[k-1];
    end
  end

  for (genvar k = L + 2; k <= M; k++) begin : g_ov
    always_ff @(posedge clk) begin
      ovl[k] <= ovl[k-1];
    end
  end

  // Heading sines and cosines wait for the second pass.
  cpec_pkg::trig_t trl [L:M];
  assign trl[L] = '{sa: sa_o[31:0], ca: ca_o[31:0], sb: sb_o[31:0], cb: cb_o[31:0]};

  for (genvar k = L + 1; k <= M; k++) begin : g_trl
    always_ff @(posedge clk) begin
      trl[k] <= trl[k-1];
    end
  end

  // Second pass: sine and cosine of the normal angle.
  logic signed [CW-1:0] cn_o;
  logic signed [CW-1:0] sn_o;
  cpec_pkg::ntrig_t nd [2*L:M];

  cpec_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b0)) u_rnorm (
    .clk(clk), .x_in(CW'(cpec_pkg::GAIN_Q30)), .y_in('0),
    .z_in(tang + cpec_pkg::QUARTER_TURN),
    .x_out(cn_o), .y_out(sn_o), .z_out()
  );

  assign nd[2*L] = '{sn: sn_o[31:0], cn: cn_o[31:0]};

  for (genvar k = 2 * L + 1; k <= M; k++) begin : g_nd
    always_ff @(posedge clk) begin
      nd[k] <= nd[k-1];
    end
  end

  // Velocity components and separation offsets; the partner's normal is negated.
  logic signed [32:0] nsn;
  logic signed [32:0] ncn;
  logic signed [55:0] m_xa1, m_xa2, m_ya1, m_ya2, m_xb1, m_xb2, m_yb1, m_yb2;
  logic signed [61:0] m_ox, m_oy;
  cpec_pkg::prod_t pr;
  cpec_pkg::ofs_t ofl [M+1:LAST];

  assign nsn = -33'(nd[M].sn);
  assign ncn = -33'(nd[M].cn);

  always_comb begin
    m_xa1 = trl[M].sa * qd[M].qa1;
    m_xa2 = nd[M].sn * qd[M].qa2;
    m_ya1 = trl[M].ca * qd[M].qa1;
    m_ya2 = nd[M].cn * qd[M].qa2;
    m_xb1 = trl[M].sb * qd[M].qb1;
    m_xb2 = nsn * qd[M].qb2;
    m_yb1 = trl[M].cb * qd[M].qb1;
    m_yb2 = ncn * qd[M].qb2;
    m_ox = nd[M].sn * ovl[M];
    m_oy = nd[M].cn * ovl[M];
  end

  always_ff @(posedge clk) begin
    pr <= '{xa1: m_xa1[53:30], xa2: m_xa2[53:30], ya1: m_ya1[53:30], ya2: m_ya2[53:30],
            xb1: m_xb1[53:30], xb2: m_xb2[53:30], yb1: m_yb1[53:30], yb2: m_yb2[53:30]};
    ofl[M+1] <= '{ox: m_ox[59:30], oy: m_oy[59:30]};
  end

  for (genvar k = M + 2; k <= LAST; k++) begin : g_ofs
    always_ff @(posedge clk) begin
      ofl[k] <= ofl[k-1];
    end
  end

  // Sum the velocity contributions of each particle.
  logic signed [CW-1:0] vxa, vya, vxb, vyb;

  always_ff @(posedge clk) begin
    vxa <= CW'(pr.xa1) + CW'(pr.xa2);
    vya <= CW'(pr.ya1) + CW'(pr.ya2);
    vxb <= CW'(pr.xb1) + CW'(pr.xb2);
    vyb <= CW'(pr.yb1) + CW'(pr.yb2);
  end

  // Third pass: new speeds and headings in polar form.
  logic signed [CW-1:0] mag_a;
  logic signed [CW-1:0] mag_b;
  logic [AW-1:0] ang_a;
  logic [AW-1:0] ang_b;

  cpec_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b1)) u_vela (
    .clk(clk), .x_in(vxa), .y_in(vya), .z_in('0),
    .x_out(mag_a), .y_out(), .z_out(ang_a)
  );

  cpec_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b1)) u_velb (
    .clk(clk), .x_in(vxb), .y_in(vyb), .z_in('0),
    .x_out(mag_b), .y_out(), .z_out(ang_b)
  );

  // Restitution scaling and heading rounding.
  logic signed [CW+17:0] rp_a;
  logic signed [CW+17:0] rp_b;
  logic signed [31:0] spd_a;
  logic signed [31:0] spd_b;
  logic [AW-1:0] hd_a;
  logic [AW-1:0] hd_b;

  assign rp_a = mag_a * $signed({1'b0, itm[V].rest});
  assign rp_b = mag_b * $signed({1'b0, itm[V].rest});

  always_ff @(posedge clk) begin
    spd_a <= rp_a[51:20];
    spd_b <= rp_b[51:20];
    hd_a <= cpec_pkg::QUARTER_TURN - ang_a + 32'h0000_8000;
    hd_b <= cpec_pkg::QUARTER_TURN - ang_b + 32'h0000_8000;
  end

  // Result register: resolved values on a hit, the request echoed otherwise.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[LAST];
    end
  end

  always_ff @(posedge clk) begin
    hit <= hitl[LAST];
    if (hitl[LAST]) begin
      new_a_x <= pos_sat(itm[LAST].ax, 31'(ofl[LAST].ox));
      new_a_y <= pos_sat(itm[LAST].ay, -31'(ofl[LAST].oy));
      new_b_x <= pos_sat(itm[LAST].bx, -31'(ofl[LAST].ox));
      new_b_y <= pos_sat(itm[LAST].by, 31'(ofl[LAST].oy));
      new_speed_a <= spd_a[31] ? 16'd0 : ((spd_a > 32'sd65535) ? 16'hFFFF : spd_a[15:0]);
      new_speed_b <= spd_b[31] ? 16'd0 : ((spd_b > 32'sd65535) ? 16'hFFFF : spd_b[15:0]);
      new_heading_a <= hd_a[31:16];
      new_heading_b <= hd_b[31:16];
    end else begin
      new_a_x <= itm[LAST].ax;
      new_a_y <= itm[LAST].ay;
      new_b_x <= itm[LAST].bx;
      new_b_y <= itm[LAST].by;
      new_speed_a <= itm[LAST].spa;
      new_speed_b <= itm[LAST].spb;
      new_heading_a <= itm[LAST].ha;
      new_heading_b <= itm[LAST].hb;
    end
  end

  // Every accepted request yields a result, and every result has a matching request.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("result missing after accepted request");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without a matching request");

  // A detected overlap always pushes the particles apart.
  a_push: assert property (@(posedge clk) disable iff (rst)
    (vld[L+1] && hitl[L+1]) |-> (ovl[L+1] > 30'sd0))
    else $error("overlap without a positive push distance");

endmodule

// ===== sv/cpec_cordic.sv =====
`timescale 1ns / 1ps

module cpec_cordic #(
  parameter int STEPS = 16,
  parameter bit VECTOR = 1'b0
) (
  input  logic clk,
  input  logic signed [cpec_pkg::CW-1:0] x_in,
  input  logic signed [cpec_pkg::CW-1:0] y_in,
  input  logic [cpec_pkg::AW-1:0] z_in,
  output logic signed [cpec_pkg::CW-1:0] x_out,
  output logic signed [cpec_pkg::CW-1:0] y_out,
  output logic [cpec_pkg::AW-1:0] z_out
);

  localparam int CW = cpec_pkg::CW;
  localparam int AW = cpec_pkg::AW;

  logic signed [CW-1:0] xs [STEPS+1];
  logic signed [CW-1:0] ys [STEPS+1];
  logic [AW-1:0] zs [STEPS+1];
  logic fl [STEPS+1];

  generate
    if (VECTOR) begin : g_vec
      // Fold the left half plane over and note the zero vector.
      always_ff @(posedge clk) begin
        fl[0] <= (x_in == '0) && (y_in == '0);
        if (x_in[CW-1]) begin
          xs[0] <= -x_in;
          ys[0] <= -y_in;
          zs[0] <= z_in + cpec_pkg::HALF_TURN;
        end else begin
          xs[0] <= x_in;
          ys[0] <= y_in;
          zs[0] <= z_in;
        end
      end

      // One micro-rotation per stage, driving y toward zero.
      for (genvar i = 0; i < STEPS; i++) begin : g_it
        always_ff @(posedge clk) begin
          fl[i+1] <= fl[i];
          if (!ys[i][CW-1]) begin
            xs[i+1] <= xs[i] + (ys[i] >>> i);
            ys[i+1] <= ys[i] - (xs[i] >>> i);
            zs[i+1] <= zs[i] + cpec_pkg::atan_of(i);
          end else begin
            xs[i+1] <= xs[i] - (ys[i] >>> i);
            ys[i+1] <= ys[i] + (xs[i] >>> i);
            zs[i+1] <= zs[i] - cpec_pkg::atan_of(i);
          end
        end
      end

      // Gain compensation of the magnitude.
      logic signed [CW+30:0] gp;
      assign gp = xs[STEPS] * cpec_pkg::GAIN_Q30;

      always_ff @(posedge clk) begin
        x_out <= fl[STEPS] ? '0 : gp[CW+29:30];
        y_out <= ys[STEPS];
        z_out <= fl[STEPS] ? '0 : zs[STEPS];
      end
    end else begin : g_rot
      logic [AW-1:0] zq;
      logic flip;
      assign zq = z_in + cpec_pkg::QUARTER_TURN;
      assign flip = zq[AW-1];

      // Bring the angle into the right half plane; the result is negated later.
      always_ff @(posedge clk) begin
        fl[0] <= flip;
        xs[0] <= x_in;
        ys[0] <= y_in;
        zs[0] <= flip ? z_in - cpec_pkg::HALF_TURN : z_in;
      end

      // One micro-rotation per stage, driving z toward zero.
      for (genvar i = 0; i < STEPS; i++) begin : g_it
        always_ff @(posedge clk) begin
          fl[i+1] <= fl[i];
          if (!zs[i][AW-1]) begin
            xs[i+1] <= xs[i] - (ys[i] >>> i);
            ys[i+1] <= ys[i] + (xs[i] >>> i);
            zs[i+1] <= zs[i] - cpec_pkg::atan_of(i);
          end else begin
            xs[i+1] <= xs[i] + (ys[i] >>> i);
            ys[i+1] <= ys[i] - (xs[i] >>> i);
            zs[i+1] <= zs[i] + cpec_pkg::atan_of(i);
          end
        end
      end

      always_ff @(posedge clk) begin
        x_out <= fl[STEPS] ? -xs[STEPS] : xs[STEPS];
        y_out <= fl[STEPS] ? -ys[STEPS] : ys[STEPS];
        z_out <= zs[STEPS];
      end
    end
  endgenerate

endmodule

// ===== sv/cpec_div.sv =====
`timescale 1ns / 1ps

module cpec_div (
  input  logic clk,
  input  logic signed [cpec_pkg::NUM_W-1:0] num,
  input  logic [cpec_pkg::DEN_W-1:0] den,
  output logic signed [cpec_pkg::QUO_W:0] quo
);

  localparam int NUM_W = cpec_pkg::NUM_W;
  localparam int DEN_W = cpec_pkg::DEN_W;
  localparam int QUO_W = cpec_pkg::QUO_W;

  logic [DEN_W-1:0] rem [QUO_W+1];
  logic [QUO_W-1:0] nq [QUO_W+1];
  logic [DEN_W-1:0] dv [QUO_W+1];
  logic ng [QUO_W+1];
  logic [NUM_W-1:0] mag;

  // Work on the magnitude; the top bits already stand below the divisor.
  assign mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);

  always_ff @(posedge clk) begin
    ng[0] <= num[NUM_W-1];
    dv[0] <= den;
    rem[0] <= {1'b0, mag[NUM_W-2:QUO_W]};
    nq[0] <= mag[QUO_W-1:0];
  end

  // Restoring division, one quotient bit per stage.
  for (genvar i = 0; i < QUO_W; i++) begin : g_it
    logic [DEN_W:0] trial;
    logic ge;
    assign trial = {rem[i], nq[i][QUO_W-1]};
    assign ge = trial >= {1'b0, dv[i]};
    always_ff @(posedge clk) begin
      ng[i+1] <= ng[i];
      dv[i+1] <= dv[i];
      rem[i+1] <= ge ? DEN_W'(trial - {1'b0, dv[i]}) : trial[DEN_W-1:0];
      nq[i+1] <= {nq[i][QUO_W-2:0], ge};
    end
  end

  // Restore the sign, truncating toward zero.
  always_ff @(posedge clk) begin
    quo <= ng[QUO_W] ? -$signed({1'b0, nq[QUO_W]}) : $signed({1'b0, nq[QUO_W]});
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int STEPS = 16;
  localparam int LATENCY = 2 * (STEPS + 2) + STEPS + 7;
  localparam int RANDOM_ITEMS = 1100;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic hit;
    logic [23:0] ax;
    logic [23:0] ay;
    logic [15:0] spa;
    logic [15:0] ha;
    logic [23:0] bx;
    logic [23:0] by;
    logic [15:0] spb;
    logic [15:0] hb;
  } outcome_t;

  typedef struct {
    cpec_pkg::item_t pair;
    bit    apart;
  } vector_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [23:0] pos_a_x = '0, pos_a_y = '0, pos_b_x = '0, pos_b_y = '0;
  logic [15:0] speed_a = '0, heading_a = '0, mass_a = '0;
  logic [15:0] speed_b = '0, heading_b = '0, mass_b = '0;
  logic [23:0] contact_distance = '0;
  logic [16:0] restitution = '0;
  logic done, hit;
  logic signed [23:0] new_a_x, new_a_y, new_b_x, new_b_y;
  logic [15:0] new_speed_a, new_heading_a, new_speed_b, new_heading_b;

  outcome_t pending_outcomes[$];
  int mismatches = 0;
  int resolved = 0;
  int checked = 0;
  bit expect_apart = 1'b0;

  // Arctangent of 2^-i as a binary angle.
  const logic [31:0] atan_step[24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  circle_pair_elastic_collision #(.CORDIC_STEPS(STEPS)) dut (.*);

  always #1 clk = ~clk;

  // Rotation mode: sine and cosine in Q30 of a binary angle.
  function automatic void rotate_unit(input logic [31:0] a, output longint s,
                                      output longint c);
    logic [31:0] z;
    logic [31:0] shifted;
    longint x, y, xs, ys;
    bit flip;
    shifted = a + cpec_pkg::QUARTER_TURN;
    flip = shifted[31];
    z = flip ? a - cpec_pkg::HALF_TURN : a;
    x = 652032874;
    y = 0;
    for (int i = 0; i < STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (!z[31]) begin
        x -= ys; y += xs; z = z - atan_step[i];
      end else begin
        x += ys; y -= xs; z = z + atan_step[i];
      end
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  // Vectoring mode: magnitude and atan2(y, x).
  function automatic void vector_polar(input longint x, input longint y, output longint mag,
                                       output logic [31:0] ang);
    longint xs, ys;
    logic [31:0] z;
    z = '0;
    if (x == 0 && y == 0) begin
      mag = 0; ang = '0;
      return;
    end
    if (x < 0) begin
      x = -x; y = -y; z = cpec_pkg::HALF_TURN;
    end
    for (int i = 0; i < STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z = z + atan_step[i];
      end else begin
        x -= ys; y += xs; z = z - atan_step[i];
      end
    end
    mag = (x * 652032874) >>> 30;
    ang = z;
  endfunction

  // Sum of two polar velocities, returned as magnitude and heading.
  function automatic void velocity_sum(input logic [31:0] h1, input longint s1,
                                       input logic [31:0] h2, input longint s2,
                                       output longint mag, output logic [31:0] head);
    longint sa, ca, sb, cb, x, y;
    logic [31:0] t;
    rotate_unit(h1, sa, ca);
    rotate_unit(h2, sb, cb);
    x = ((sa * s1) >>> 30) + ((sb * s2) >>> 30);
    y = ((ca * s1) >>> 30) + ((cb * s2) >>> 30);
    vector_polar(x, y, mag, t);
    head = cpec_pkg::QUARTER_TURN - t;
  endfunction

  function automatic logic [15:0] scaled_speed(input longint mag, input longint rest);
    longint v;
    v = (mag * rest) >>> 20;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[15:0];
  endfunction

  function automatic logic [15:0] rounded_heading(input logic [31:0] h);
    logic [31:0] r;
    r = h + 32'h8000;
    return r[31:16];
  endfunction

  function automatic logic [23:0] pushed_position(input longint p8, input longint d12);
    longint v;
    v = p8 + ((d12 + 8) >>> 4);
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v[23:0];
  endfunction

  // Works out the resolved pair, or the echo when the circles do not overlap.
  function automatic outcome_t resolve_pair(input cpec_pkg::item_t p);
    outcome_t r;
    longint ax, ay, bx, by, ma, mb, total, sa12, sb12, cd12, rest;
    longint sep, mag_a, mag_b, ov, sn, cn, ox, oy;
    logic [31:0] tang, nang, nha, nhb;
    ax = p.ax; ay = p.ay; bx = p.bx; by = p.by;
    cd12 = longint'(p.cd) * 16;
    rest = p.rest;
    vector_polar((ax - bx) * 16, (ay - by) * 16, sep, tang);
    if (!(sep < cd12)) begin
      r = '{1'b0, p.ax, p.ay, p.spa, p.ha, p.bx, p.by, p.spb, p.hb};
      return r;
    end
    ma = (p.ma == 0) ? 1 : p.ma;
    mb = (p.mb == 0) ? 1 : p.mb;
    total = ma + mb;
    sa12 = longint'(p.spa) * 16;
    sb12 = longint'(p.spb) * 16;
    nang = tang + cpec_pkg::QUARTER_TURN;
    velocity_sum({p.ha, 16'h0}, sa12 * (ma - mb) / total, nang, 2 * sb12 * mb / total,
                 mag_a, nha);
    velocity_sum({p.hb, 16'h0}, sb12 * (mb - ma) / total, nang + cpec_pkg::HALF_TURN,
                 2 * sa12 * ma / total, mag_b, nhb);
    ov = (cd12 - sep + 4096) >>> 1;
    rotate_unit(nang, sn, cn);
    ox = (sn * ov) >>> 30;
    oy = (cn * ov) >>> 30;
    r.hit = 1'b1;
    r.ax = pushed_position(ax, ox);
    r.ay = pushed_position(ay, -oy);
    r.spa = scaled_speed(mag_a, rest);
    r.ha = rounded_heading(nha);
    r.bx = pushed_position(bx, -ox);
    r.by = pushed_position(by, oy);
    r.spb = scaled_speed(mag_b, rest);
    r.hb = rounded_heading(nhb);
    return r;
  endfunction

  // Record the expectation for every accepted request.
  always @(posedge clk) begin
    cpec_pkg::item_t p;
    outcome_t e;
    if (!rst && start && !busy) begin
      p = '{pos_a_x, pos_a_y, speed_a, heading_a, mass_a, pos_b_x, pos_b_y, speed_b,
            heading_b, mass_b, contact_distance, restitution};
      e = resolve_pair(p);
      // Rows marked as apart carry a typed echo instead of the predictor.
      if (expect_apart)
        e = '{1'b0, p.ax, p.ay, p.spa, p.ha, p.bx, p.by, p.spb, p.hb};
      pending_outcomes.push_back(e);
    end
  end

  // Compare each result with the oldest expectation.
  always @(posedge clk) begin
    outcome_t got, want;
    if (!rst && done) begin
      got = '{hit, new_a_x, new_a_y, new_speed_a, new_heading_a, new_b_x, new_b_y,
              new_speed_b, new_heading_b};
      if (pending_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("tb: result with nothing expected: %p", got);
      end else begin
        want = pending_outcomes.pop_front();
        checked++;
        if (got.hit) resolved++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("tb: mismatch\n  expected %p\n  actual   %p", want, got);
        end
      end
    end
  end

  // Holds one request on the ports until it is taken.
  task automatic send_request(input cpec_pkg::item_t p, input bit apart);
    start <= 1'b1;
    pos_a_x <= p.ax; pos_a_y <= p.ay; speed_a <= p.spa; heading_a <= p.ha;
    mass_a <= p.ma; pos_b_x <= p.bx; pos_b_y <= p.by; speed_b <= p.spb;
    heading_b <= p.hb; mass_b <= p.mb; contact_distance <= p.cd;
    restitution <= p.rest;
    expect_apart <= apart;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic pause_sender(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Mostly close pairs, many of which overlap; the rest is full-range noise.
  function automatic cpec_pkg::item_t random_pair();
    cpec_pkg::item_t p;
    int mode;
    mode = $urandom_range(0, 99);
    p = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
          $urandom, $urandom, $urandom, $urandom};
    if (mode < 80) begin
      p.bx = p.ax + 24'(int'($urandom_range(0, 8191)) - 4096);
      p.by = p.ay + 24'(int'($urandom_range(0, 8191)) - 4096);
      p.cd = 24'($urandom_range(0, 8191));
      if ($urandom_range(0, 9) == 0) p.ma = '0;
      if ($urandom_range(0, 9) == 0) p.mb = '0;
      if ($urandom_range(0, 3) != 0) p.rest = 17'($urandom_range(0, 65536));
      if ($urandom_range(0, 4) == 0) p.spa = 16'($urandom_range(0, 255));
    end
    return p;
  endfunction

  vector_t directed[$];

  initial begin
    cpec_pkg::item_t p;
    int left, burst;
    // Far apart or zero radius sum: the request passes through unchanged.
    directed.push_back('{'{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b1});
    directed.push_back('{'{24'h7FFFFF, 24'h800000, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                           24'h800000, 24'h7FFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                           24'hFFFFFF, 17'h1FFFF}, 1'b1});
    directed.push_back('{'{100, 200, 300, 400, 256, 5000, 200, 300, 400, 256, 16, 65536},
                         1'b1});
    // Coincident centres.
    directed.push_back('{'{1000, 1000, 512, 16384, 256, 1000, 1000, 256, 49152, 256,
                           512, 65536}, 1'b0});
    // Zero masses on both sides.
    directed.push_back('{'{0, 0, 1024, 0, 0, 300, 0, 1024, 32768, 0, 1024, 65536}, 1'b0});
    // Both particles at rest.
    directed.push_back('{'{0, 0, 0, 0, 256, 200, 100, 0, 0, 256, 1024, 65536}, 1'b0});
    // Restitution of zero, exactly one and above one.
    directed.push_back('{'{0, 0, 65535, 16384, 256, 256, 0, 65535, 49152, 256, 2048, 0},
                         1'b0});
    directed.push_back('{'{0, 0, 65535, 16384, 256, 256, 0, 65535, 49152, 256, 2048,
                           65536}, 1'b0});
    directed.push_back('{'{0, 0, 65535, 16384, 256, 256, 0, 65535, 49152, 256, 2048,
                           17'h1FFFF}, 1'b0});
    // Pairs at the edges of the position range, so the push saturates.
    directed.push_back('{'{24'h7FFFFF, 24'h7FFFFF, 256, 0, 256, 24'h7FFF00, 24'h7FFF00,
                           256, 0, 256, 24'hFFFFFF, 65536}, 1'b0});
    directed.push_back('{'{24'h800000, 24'h800000, 256, 0, 256, 24'h800100, 24'h800100,
                           256, 0, 256, 24'hFFFFFF, 65536}, 1'b0});
    // Cardinal headings, heavy against light, and maximal masses.
    directed.push_back('{'{0, 0, 2560, 0, 65535, 0, 256, 512, 32768, 1, 512, 65536}, 1'b0});
    directed.push_back('{'{0, 0, 2560, 16384, 1, 256, 0, 512, 49152, 65535, 512, 65536},
                         1'b0});
    directed.push_back('{'{-500, 300, 4000, 40000, 65535, -400, 350, 3000, 7000, 65535,
                           400, 50000}, 1'b0});

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) send_request(directed[i].pair, directed[i].apart);
    pause_sender($urandom_range(0, 5));

    // Random part in bursts without gaps, some of them long.
    left = RANDOM_ITEMS;
    while (left > 0) begin
      burst = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      for (int k = 0; k < burst && left > 0; k++, left--) begin
        p = random_pair();
        send_request(p, 1'b0);
      end
      pause_sender($urandom_range(1, 8));
    end

    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    $display("tb: %0d requests checked, %0d of them resolved as collisions.", checked,
             resolved);
    $display("tb: %0d mismatches.", mismatches);
    if (mismatches == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

  // Watchdog.
  initial begin
    #400000;
    $display("tb: timeout");
    $display("tb: FAIL");
    $finish;
  end

endmodule
